/* rtl/rdas_pkg.sv */
package rdas_pkg;

    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int RANK_W    = IDX_W + 1;
    localparam int ROT_A     = 5;
    localparam int ROT_B     = 1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [RANK_W-1:0]    t_rank;

    // one job handed from the front queue to the elimination engine
    typedef struct packed {
        t_word delta;
        t_word offset;
    } t_job;

    function automatic t_word rotl(input t_word x, input int n);
        t_word r;
        r = (x << n) | (x >> (WORD_BITS - n));
        return r;
    endfunction

    // round function; f(0) is zero
    function automatic t_word round_fn(input t_word x);
        t_word r;
        r = (rotl(x, ROT_A) & x) ^ rotl(x, ROT_B);
        return r;
    endfunction

endpackage

/* rtl/rdas_front.sv */
module rdas_front
    import rdas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_delta,
    output logic  o_full,
    output logic  o_job_valid,
    output t_job  o_job,
    input  logic  i_job_take
);

    // two-entry queue of jobs, offset worked out on entry
    t_job       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    t_job       w_job;

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_job_take && o_job_valid;

    always_comb begin
        w_job.delta  = i_delta;
        w_job.offset = round_fn(i_delta);
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop  ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_job;
        end
    end

endmodule

/* rtl/rdas_back.sv */
module rdas_back
    import rdas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_job_valid,
    input  t_job  i_job,
    output logic  o_job_take,
    input  logic  i_pop,
    output logic  o_empty,
    output t_word o_offset,
    output t_rank o_rank,
    output t_word o_basis_vector,
    output logic  o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ELIM,
        S_EMIT
    } t_state;

    t_state               r_state;
    t_word                r_rows [WORD_BITS];
    t_idx                 r_ord  [WORD_BITS];
    logic [WORD_BITS-1:0] r_used;
    t_word                r_offset;
    t_rank                r_rank;
    t_idx                 r_col;
    t_idx                 r_k;
    logic                 r_ovalid;
    t_word                r_o_offset;
    t_rank                r_o_rank;
    t_word                r_o_vec;
    logic                 r_o_last;

    logic [WORD_BITS-1:0] w_cand, w_oh;
    logic                 w_found;
    t_word                w_piv;
    t_idx                 w_idx;
    logic                 w_slot;
    logic                 w_emit_last;
    t_word                w_emit_vec;

    assign o_empty        = !r_ovalid;
    assign o_offset       = r_o_offset;
    assign o_rank         = r_o_rank;
    assign o_basis_vector = r_o_vec;
    assign o_last         = r_o_last;
    assign o_job_take     = (r_state == S_IDLE);

    assign w_slot = !r_ovalid || i_pop;

    // pivot search: lowest unused row with the current column set
    always_comb begin
        for (int r = 0; r < WORD_BITS; r++) begin
            w_cand[r] = !r_used[r] && r_rows[r][r_col];
        end
        w_oh    = w_cand & (~w_cand + t_word'(1));
        w_found = |w_cand;
        w_piv   = '0;
        w_idx   = '0;
        for (int r = 0; r < WORD_BITS; r++) begin
            w_piv = w_piv | (r_rows[r] & {WORD_BITS{w_oh[r]}});
            w_idx = w_idx | (t_idx'(r) & {IDX_W{w_oh[r]}});
        end
    end

    always_comb begin
        w_emit_vec  = (r_rank == '0) ? '0 : r_rows[r_ord[r_k]];
        w_emit_last = (r_rank == '0) || ({1'b0, r_k} + t_rank'(1) == r_rank);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_ELIM;
                    end
                end
                S_ELIM: begin
                    if (r_col == t_idx'(WORD_BITS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot && w_emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    for (int r = 0; r < WORD_BITS; r++) begin
                        r_rows[r] <= round_fn(t_word'(1) << r)
                                   ^ round_fn(i_job.delta ^ (t_word'(1) << r))
                                   ^ i_job.offset;
                    end
                    r_offset <= i_job.offset;
                    r_rank   <= '0;
                    r_col    <= '0;
                    r_k      <= '0;
                    r_used   <= '0;
                end
            end
            S_ELIM: begin
                if (w_found) begin
                    for (int r = 0; r < WORD_BITS; r++) begin
                        if (!w_oh[r] && r_rows[r][r_col]) begin
                            r_rows[r] <= r_rows[r] ^ w_piv;
                        end
                    end
                    if (r_offset[r_col]) begin
                        r_offset <= r_offset ^ w_piv;
                    end
                    r_ord[r_rank[IDX_W-1:0]] <= w_idx;
                    r_rank <= r_rank + t_rank'(1);
                    r_used <= r_used | w_oh;
                end
                r_col <= r_col + t_idx'(1);
            end
            S_EMIT: begin
                if (w_slot) begin
                    r_o_offset <= r_offset;
                    r_o_rank   <= r_rank;
                    r_o_vec    <= w_emit_vec;
                    r_o_last   <= w_emit_last;
                    r_k        <= r_k + t_idx'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/round_difference_affine_space_top.sv */
// channel  direction  handshake           beat
// input    in         i_push / o_full     i_delta
// result   out        o_empty / i_pop     o_offset, o_rank, o_basis_vector, o_last
//
// in the back end an item passes load, elimination (column by column, one shared pivot
// search and row update) and emit states; emit gives max(1, rank) result beats
// a two-entry job queue takes new inputs while the back end is busy
// synchronous active-low reset clears queue, state and result valid
// a stalled pop holds the result register and the back end waits on it
module round_difference_affine_space_top
    import rdas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_delta,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_offset,
    output logic [5:0]  o_rank,
    output logic [31:0] o_basis_vector,
    output logic        o_last
);

    logic w_job_valid;
    logic w_job_take;
    t_job w_job;

    rdas_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_delta     (i_delta),
        .o_full      (o_full),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    rdas_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job),
        .o_job_take     (w_job_take),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_offset       (o_offset),
        .o_rank         (o_rank),
        .o_basis_vector (o_basis_vector),
        .o_last         (o_last)
    );

endmodule
